@@ sv/wcm_pkg.sv @@
`timescale 1ns / 1ps

package wcm_pkg;

  localparam int CODE_W    = 2;
  localparam int SCORE_W   = 17;
  localparam int COUNT_W   = 11;
  localparam int OP_W      = 2;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;

  // op codes carried in s_tuser
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [CODE_W-1:0]  CODE_ANY  = '0;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // last member sits in the lowest bits, so a record overlays tdata directly
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CODE_W-1:0]  food;
    logic [CODE_W-1:0]  career;
    logic [CODE_W-1:0]  job;
    logic [CODE_W-1:0]  lang;
  } record_t;

  localparam int REC_W = $bits(record_t);

  // scan control from the sequencer to the match unit
  typedef struct packed {
    logic clr;
    logic vld;
  } scan_ctl_t;

endpackage

@@ sv/wildcard_match_threshold_counter_top.sv @@
`timescale 1ns / 1ps

// Record store with wildcard filtered counting. Each input item carries an
// op in s_tuser: insert appends a record (four 2-bit category codes and a
// 17-bit score) to the store, query counts stored records whose codes match
// every non-zero query code and whose score is at least the query score,
// clear empties the store, and the unused op does nothing. Every item gives
// exactly one result item: the match count (zero unless a query) in m_tdata
// and a status flag in m_tuser that is set only when an insert finds the
// store full and drops the record. A query walks the stored records through
// the single read port of the record memory, one record a cycle, into a
// shared compare and count unit, so s_tready stays low from the query's
// acceptance through the scan, wait, finish and any hold states (a query of
// an empty store answers at once). The count saturates at 2047. A finished
// result waits in an output register, and one more result can be held back
// while m_tready is low.
module wildcard_match_threshold_counter_top #(
  parameter int MAX_RECORDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // lang_code, job_code, career_code, food_code, score_value, zero pad
  input  logic [wcm_pkg::S_TDATA_W-1:0] s_tdata,
  // op
  input  logic [wcm_pkg::OP_W-1:0]      s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // match_count, zero pad
  output logic [wcm_pkg::M_TDATA_W-1:0] m_tdata,
  // status
  output logic                          m_tuser
);
  import wcm_pkg::*;

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_FIN,
    ST_HOLD
  } state_t;

  state_t               state;
  logic [CW-1:0]        rec_count;
  logic [AW-1:0]        scan_addr;
  record_t              key;
  record_t              in_rec;
  record_t              rd_rec;
  logic                 rd_vld_q;
  logic [COUNT_W-1:0]   match_count;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_status;
  logic [COUNT_W-1:0]   pend_count;
  logic                 pend_status;

  logic                 s_acc;
  logic                 full;
  logic                 wr_en;
  logic                 rd_en;
  logic                 scan_last;
  logic                 out_free;
  logic                 res_vld;
  logic [COUNT_W-1:0]   res_count;
  logic                 res_status;
  scan_ctl_t            ctl;

  assign in_rec   = record_t'(s_tdata[REC_W-1:0]);
  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(M_TDATA_W-COUNT_W){1'b0}}, out_count};
  assign m_tuser  = out_status;

  always_comb begin
    s_acc     = s_tvalid && s_tready;
    full      = (rec_count == CW'(MAX_RECORDS));
    wr_en     = s_acc && (s_tuser == OP_INSERT) && !full;
    rd_en     = (state == ST_SCAN);
    scan_last = (scan_addr == AW'(rec_count - CW'(1)));
    out_free  = !m_tvalid || m_tready;
    ctl.clr   = s_acc && (s_tuser == OP_QUERY);
    ctl.vld   = rd_vld_q;

    // result of the item in hand, if one is ready this cycle
    res_vld    = 1'b0;
    res_count  = '0;
    res_status = 1'b0;
    if (s_acc) begin
      unique case (s_tuser)
        OP_INSERT: begin
          res_vld    = 1'b1;
          res_status = full;
        end
        OP_QUERY: res_vld = (rec_count == '0);
        OP_CLEAR: res_vld = 1'b1;
        default:  res_vld = 1'b1;
      endcase
    end else if (state == ST_FIN) begin
      res_vld   = 1'b1;
      res_count = match_count;
    end
  end

  wcm_store #(
    .DEPTH (MAX_RECORDS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rec_count[AW-1:0]),
    .wr_data (in_rec),
    .rd_en   (rd_en),
    .rd_addr (scan_addr),
    .rd_data (rd_rec)
  );

  wcm_match u_match (
    .clk   (clk),
    .ctl   (ctl),
    .key   (key),
    .rec   (rd_rec),
    .count (match_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rec_count <= '0;
      rd_vld_q  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;

      // new result goes straight out, a parked one follows once the output drains
      if (res_vld && out_free) begin
        m_tvalid   <= 1'b1;
        out_count  <= res_count;
        out_status <= res_status;
      end else if (state == ST_HOLD && out_free) begin
        m_tvalid   <= 1'b1;
        out_count  <= pend_count;
        out_status <= pend_status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (res_vld && !out_free) begin
        pend_count  <= res_count;
        pend_status <= res_status;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            if (wr_en) begin
              rec_count <= rec_count + CW'(1);
            end
            if (s_tuser == OP_CLEAR) begin
              rec_count <= '0;
            end
            if (s_tuser == OP_QUERY && rec_count != '0) begin
              state     <= ST_SCAN;
              scan_addr <= '0;
              key       <= in_rec;
            end else if (!out_free) begin
              state <= ST_HOLD;
            end
          end
        end
        ST_SCAN: begin
          scan_addr <= scan_addr + AW'(1);
          if (scan_last) begin
            state <= ST_WAIT;
          end
        end
        // last record is being counted
        ST_WAIT: state <= ST_FIN;
        ST_FIN:  state <= out_free ? ST_IDLE : ST_HOLD;
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rec_count <= CW'(MAX_RECORDS))
    else $error("record count beyond store depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CW'(scan_addr) < rec_count)
    else $error("scan reads past the stored records");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_INSERT && rec_count == CW'(MAX_RECORDS))
      |=> $stable(rec_count))
    else $error("insert into a full store changed the record count");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[COUNT_W-1:0] == '0)
    else $error("dropped insert reports a nonzero count");
`endif

endmodule

@@ sv/wcm_store.sv @@
`timescale 1ns / 1ps

module wcm_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  wcm_pkg::record_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output wcm_pkg::record_t rd_data
);
  import wcm_pkg::*;

  record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/wcm_match.sv @@
`timescale 1ns / 1ps

module wcm_match (
  input  logic                        clk,
  input  wcm_pkg::scan_ctl_t          ctl,
  input  wcm_pkg::record_t            key,
  input  wcm_pkg::record_t            rec,
  output logic [wcm_pkg::COUNT_W-1:0] count
);
  import wcm_pkg::*;

  logic hit;

  always_comb begin
    hit = (key.lang   == CODE_ANY || key.lang   == rec.lang)   &&
          (key.job    == CODE_ANY || key.job    == rec.job)    &&
          (key.career == CODE_ANY || key.career == rec.career) &&
          (key.food   == CODE_ANY || key.food   == rec.food)   &&
          (rec.score >= key.score);
  end

  // saturating hit counter
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      count <= '0;
    end else if (ctl.vld && hit && count != COUNT_MAX) begin
      count <= count + COUNT_W'(1);
    end
  end

endmodule

@@ dv/wildcard_match_threshold_counter_top_tb.sv @@
`timescale 1ns / 1ps

module wildcard_match_threshold_counter_top_tb;
  import wcm_pkg::*;

  localparam int MAX_RECORDS = 1024;
  localparam int ITEM_W      = SCORE_W + 4 * CODE_W;
  localparam int RAND_ITEMS  = 520;
  localparam int HOLD_AT     = 60;      // result index where the long back-pressure starts
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 64;
  localparam int LIMIT       = 2000000; // far above the slowest legal run

  // op code the block leaves unused
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam logic [SCORE_W-1:0] SCORE_TOP = '1;

  // one request item as it travels on the slave side
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CODE_W-1:0]  lang;
    logic [CODE_W-1:0]  job;
    logic [CODE_W-1:0]  career;
    logic [CODE_W-1:0]  food;
    logic [SCORE_W-1:0] score;
  } request_t;

  // one answer item as it leaves on the master side
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               status;
  } answer_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [OP_W-1:0]      s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  wildcard_match_threshold_counter_top #(
    .MAX_RECORDS(MAX_RECORDS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // requests waiting to be driven, filled once at time zero
  request_t request_q[$];
  // answers predicted at input acceptance, oldest first
  answer_t  expected_answers[$];

  // shadow copy of the record store
  record_t  stored_recs[MAX_RECORDS];
  int       stored_n = 0;

  int errors    = 0;
  int sent_n    = 0;
  int got_n     = 0;
  int n_insert  = 0;
  int n_query   = 0;
  int n_clear   = 0;
  int n_other   = 0;
  int n_dropped = 0;
  int peak_n    = 0;
  int cycle_n   = 0;

  // generator bookkeeping
  int gen_stored = 0;
  logic [SCORE_W-1:0] last_score = '0;

  // applies one accepted request to the shadow store and returns its answer
  function automatic answer_t apply_request(request_t rq);
    answer_t ans;
    record_t rec;
    ans.count  = '0;
    ans.status = 1'b0;
    case (rq.op)
      OP_INSERT: begin
        if (stored_n < MAX_RECORDS) begin
          rec.lang   = rq.lang;
          rec.job    = rq.job;
          rec.career = rq.career;
          rec.food   = rq.food;
          rec.score  = rq.score;
          stored_recs[stored_n] = rec;
          stored_n++;
        end else begin
          ans.status = 1'b1;
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < stored_n; i++) begin
          rec = stored_recs[i];
          // a non-zero query code must match exactly, zero matches anything
          if ((rq.lang == CODE_ANY || rq.lang == rec.lang) &&
              (rq.job == CODE_ANY || rq.job == rec.job) &&
              (rq.career == CODE_ANY || rq.career == rec.career) &&
              (rq.food == CODE_ANY || rq.food == rec.food) &&
              rec.score >= rq.score && ans.count != COUNT_MAX)
            ans.count++;
        end
      end
      OP_CLEAR: stored_n = 0;
      default: ;
    endcase
    return ans;
  endfunction

  // wait cycles per item, with quiet windows of back-to-back traffic
  function automatic int pick_wait(int n, int period, int quiet);
    if ((n % period) < quiet)
      return 0;
    return $urandom_range(0, 5);
  endfunction

  task automatic queue_item(logic [OP_W-1:0] op, logic [CODE_W-1:0] lang,
                            logic [CODE_W-1:0] job, logic [CODE_W-1:0] career,
                            logic [CODE_W-1:0] food, logic [SCORE_W-1:0] score);
    request_t rq;
    rq = '{op: op, lang: lang, job: job, career: career, food: food, score: score};
    request_q = {request_q, rq};
  endtask

  // insert with full-range codes and a score from the edges or the middle
  task automatic add_insert();
    logic [SCORE_W-1:0] sc;
    case ($urandom_range(0, 7))
      0:       sc = '0;
      1:       sc = SCORE_TOP;
      2, 3:    sc = SCORE_W'($urandom_range(0, 31));
      default: sc = SCORE_W'($urandom);
    endcase
    queue_item(OP_INSERT, CODE_W'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 3)),
               CODE_W'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 3)), sc);
    last_score = sc;
    if (gen_stored < MAX_RECORDS)
      gen_stored++;
  endtask

  // query with wildcards about half the time and thresholds from the edges, the last inserted score or random
  task automatic add_query();
    logic [SCORE_W-1:0] thr;
    logic [CODE_W-1:0]  c[4];
    for (int k = 0; k < 4; k++)
      c[k] = $urandom_range(0, 1) ? CODE_ANY : CODE_W'($urandom_range(1, 3));
    case ($urandom_range(0, 9))
      0, 1:    thr = '0;
      2:       thr = SCORE_TOP;
      3, 4:    thr = last_score;
      5, 6:    thr = SCORE_W'($urandom_range(0, 31));
      default: thr = SCORE_W'($urandom);
    endcase
    queue_item(OP_QUERY, c[0], c[1], c[2], c[3], thr);
  endtask

  // driver: pops a request when the bus slot frees up, then idles its drawn gap
  int drv_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      drv_gap  <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (drv_gap > 0) begin
        drv_gap  <= drv_gap - 1;
        s_tvalid <= 1'b0;
      end else if (request_q.size() != 0) begin
        request_t rq;
        rq = request_q.pop_front();
        s_tdata  <= {{(S_TDATA_W-ITEM_W){1'b0}}, rq.score, rq.food, rq.career, rq.job,
                     rq.lang};
        s_tuser  <= rq.op;
        s_tvalid <= 1'b1;
        drv_gap  <= pick_wait(sent_n, 150, 40);
        sent_n++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predicts on input acceptance, then checks any result taken in the
  // same edge; both use pre-edge values so block ordering does not matter
  int      stall_left = 0;
  int      stall;
  request_t seen;
  answer_t  want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        seen.op     = s_tuser;
        seen.lang   = s_tdata[1:0];
        seen.job    = s_tdata[3:2];
        seen.career = s_tdata[5:4];
        seen.food   = s_tdata[7:6];
        seen.score  = s_tdata[8 +: SCORE_W];
        want = apply_request(seen);
        expected_answers = {expected_answers, want};
        case (seen.op)
          OP_INSERT: n_insert++;
          OP_QUERY:  n_query++;
          OP_CLEAR:  n_clear++;
          default:   n_other++;
        endcase
        if (want.status)
          n_dropped++;
        if (stored_n > peak_n)
          peak_n = stored_n;
      end

      if (m_tvalid && m_tready) begin
        if (expected_answers.size() == 0) begin
          $error("result item with nothing expected: match_count %0d status %0b",
                 m_tdata[COUNT_W-1:0], m_tuser);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (m_tdata[COUNT_W-1:0] !== want.count) begin
            $error("match_count mismatch: expected %0d actual %0d", want.count,
                   m_tdata[COUNT_W-1:0]);
            errors++;
          end
          if (m_tuser !== want.status) begin
            $error("status mismatch: expected %0b actual %0b", want.status, m_tuser);
            errors++;
          end
        end
        got_n++;
        // one long hold-off so the output side fills and s_tready drops
        stall = (got_n == HOLD_AT) ? HOLD_CYCLES : pick_wait(got_n, 130, 35);
        stall_left <= stall;
        m_tready   <= (stall == 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else begin
        stall_left <= 0;
        m_tready   <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  int rand_left;
  int run_len;
  int pick;

  initial begin
    // directed: empty store, unused op, extreme fields, exact threshold,
    // clear with stray fields
    queue_item(OP_QUERY, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, '0);
    queue_item(OP_NONE, 2'd3, 2'd3, 2'd3, 2'd3, SCORE_TOP);
    queue_item(OP_INSERT, 2'd3, 2'd3, 2'd3, 2'd3, SCORE_TOP);
    queue_item(OP_INSERT, 2'd0, 2'd0, 2'd0, 2'd0, '0);
    queue_item(OP_INSERT, 2'd1, 2'd2, 2'd1, 2'd2, 17'h15555);
    queue_item(OP_INSERT, 2'd2, 2'd1, 2'd2, 2'd1, 17'h0AAAA);
    queue_item(OP_QUERY, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, '0);
    queue_item(OP_QUERY, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, SCORE_TOP);
    queue_item(OP_QUERY, 2'd3, CODE_ANY, CODE_ANY, CODE_ANY, '0);
    queue_item(OP_QUERY, CODE_ANY, 2'd2, CODE_ANY, CODE_ANY, 17'h15555);
    queue_item(OP_QUERY, CODE_ANY, 2'd2, CODE_ANY, CODE_ANY, 17'h15556);
    queue_item(OP_QUERY, 2'd1, 2'd2, 2'd1, 2'd2, '0);
    queue_item(OP_QUERY, 2'd3, 2'd3, 2'd3, 2'd3, SCORE_TOP);
    queue_item(OP_QUERY, 2'd1, 2'd1, CODE_ANY, CODE_ANY, '0);
    queue_item(OP_NONE, 2'd1, 2'd2, 2'd3, 2'd1, 17'h1);
    queue_item(OP_QUERY, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, '0);
    queue_item(OP_CLEAR, 2'd3, 2'd3, 2'd3, 2'd3, SCORE_TOP);
    queue_item(OP_QUERY, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, '0);
    queue_item(OP_INSERT, 2'd2, 2'd2, 2'd2, 2'd2, 17'h10000);
    queue_item(OP_QUERY, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, 17'h10000);
    queue_item(OP_CLEAR, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, '0);

    // random runs: mostly inserts followed by queries over them, store kept
    // moderate so scans stay short, with occasional clears and unused ops
    rand_left = RAND_ITEMS;
    while (rand_left > 0) begin
      if (gen_stored > 300 || $urandom_range(0, 3) == 0) begin
        queue_item(OP_CLEAR, CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom),
                   CODE_W'($urandom), SCORE_W'($urandom));
        gen_stored = 0;
        rand_left--;
      end
      run_len = $urandom_range(4, 40);
      repeat (run_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          add_insert();
          rand_left--;
        end else if (pick < 94) begin
          add_query();
          rand_left--;
        end else begin
          // does nothing in the block, not counted in RAND_ITEMS
          queue_item(OP_NONE, CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom),
                     CODE_W'($urandom), SCORE_W'($urandom));
        end
      end
    end

    // tail: unused op, inserts and queries around a final clear
    queue_item(OP_NONE, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, '0);
    add_insert();
    queue_item(OP_QUERY, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, SCORE_TOP);
    queue_item(OP_CLEAR, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, '0);
    queue_item(OP_QUERY, CODE_ANY, CODE_ANY, CODE_ANY, CODE_ANY, '0);
    add_insert();
    add_query();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain: everything sent, nothing outstanding, then a quiet tail
    while (request_q.size() != 0 || s_tvalid || expected_answers.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    if (expected_answers.size() != 0) begin
      $error("%0d expected result items never arrived", expected_answers.size());
      errors++;
    end

    $display("covered %0d items: %0d inserts (%0d dropped on a full store), %0d queries,",
             sent_n, n_insert, n_dropped, n_query);
    $display("%0d clears, %0d unused ops, store peaked at %0d records, %0d results checked",
             n_clear, n_other, peak_n, got_n);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
sv/wcm_pkg.sv
sv/wcm_store.sv
sv/wcm_match.sv
sv/wildcard_match_threshold_counter_top.sv
dv/wildcard_match_threshold_counter_top_tb.sv
